// ----- design/assert_macros.svh -----
// Assertion macros shared by the line rasteriser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/blp_pkg.sv -----
// Shared types and constants of the Bresenham line rasteriser.
package blp_pkg;

    // Width of a coordinate field on the ports
    localparam int CoordW = 6;
    // Default tile coordinate width
    localparam int CoordBitsDefault = 6;
    // Colour width
    localparam int ColorW = 32;
    // Entries in the queue between front and back
    localparam int QueueDepth = 2;
    localparam int QueueCntW = $clog2(QueueDepth + 1);

    // One line command
    typedef struct packed {
        logic [CoordW-1:0] start_x;
        logic [CoordW-1:0] start_y;
        logic [CoordW-1:0] end_x;
        logic [CoordW-1:0] end_y;
        logic [ColorW-1:0] line_color;
    } t_cmd;

    // One emitted pixel
    typedef struct packed {
        logic [CoordW-1:0] pixel_x;
        logic [CoordW-1:0] pixel_y;
        logic [ColorW-1:0] pixel_color;
        logic              last_pixel;
    } t_pixel;

    // Classified line, ready for the walker
    typedef struct packed {
        logic              steep;
        logic              minor_up;
        logic [CoordW-1:0] m0;
        logic [CoordW-1:0] n0;
        logic [CoordW-1:0] dm;
        logic [CoordW-1:0] dn;
        logic [ColorW-1:0] color;
    } t_desc;

endpackage

// ----- design/blp_front.sv -----
// Front end: classifies a line command into a walk descriptor.
module blp_front #(
    parameter int COORD_BITS = blp_pkg::CoordBitsDefault
) (
    input  logic           i_start,
    input  logic           i_full,
    input  blp_pkg::t_cmd  i_cmd,
    output logic           o_push,
    output blp_pkg::t_desc o_desc
);

    localparam logic [blp_pkg::CoordW-1:0] Mask =
        blp_pkg::CoordW'((1 << COORD_BITS) - 1);

    logic [blp_pkg::CoordW-1:0] ax, ay, bx, by;
    logic [blp_pkg::CoordW-1:0] ext_x, ext_y;
    logic                       steep;
    logic [blp_pkg::CoordW-1:0] pm0, pn0, pm1, pn1;
    logic [blp_pkg::CoordW-1:0] m0, n0, m1, n1;
    logic                       accepted;

    assign accepted = i_start && !i_full;

    // Endpoints within the tile, extents and steepness
    always_comb begin
        ax    = i_cmd.start_x & Mask;
        ay    = i_cmd.start_y & Mask;
        bx    = i_cmd.end_x & Mask;
        by    = i_cmd.end_y & Mask;
        ext_x = (bx > ax) ? bx - ax : ax - bx;
        ext_y = (by > ay) ? by - ay : ay - by;
        steep = ext_x < ext_y;
    end

    // Major/minor selection, then order by major coordinate
    always_comb begin
        pm0 = steep ? ay : ax;
        pn0 = steep ? ax : ay;
        pm1 = steep ? by : bx;
        pn1 = steep ? bx : by;
        if (pm0 > pm1) begin
            m0 = pm1;
            n0 = pn1;
            m1 = pm0;
            n1 = pn0;
        end else begin
            m0 = pm0;
            n0 = pn0;
            m1 = pm1;
            n1 = pn1;
        end
    end

    // Zero-length lines are dropped here
    always_comb begin
        o_push          = accepted && (m0 != m1);
        o_desc.steep    = steep;
        o_desc.minor_up = n1 > n0;
        o_desc.m0       = m0;
        o_desc.n0       = n0;
        o_desc.dm       = m1 - m0;
        o_desc.dn       = (n1 > n0) ? n1 - n0 : n0 - n1;
        o_desc.color    = i_cmd.line_color;
    end

endmodule

// ----- design/blp_queue.sv -----
// Two-entry queue of walk descriptors between front and back.
`include "assert_macros.svh"

module blp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  blp_pkg::t_desc i_desc,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output blp_pkg::t_desc o_desc
);

    blp_pkg::t_desc                    r_q [blp_pkg::QueueDepth];
    logic [blp_pkg::QueueCntW-1:0]     r_cnt;
    logic [blp_pkg::QueueCntW-1:0]     n_cnt;
    logic                              wr_slot;

    assign o_full  = r_cnt == blp_pkg::QueueCntW'(blp_pkg::QueueDepth);
    assign o_valid = r_cnt != '0;
    assign o_desc  = r_q[0];

    // Occupancy and write position after a same-cycle pop
    always_comb begin
        wr_slot = r_cnt[0] ^ i_pop;
        n_cnt   = r_cnt + blp_pkg::QueueCntW'(i_push) - blp_pkg::QueueCntW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Shift on pop, write behind the last live entry
    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            // a push into a one-entry queue lands straight in the head slot
            r_q[0] <= (i_push && !wr_slot) ? i_desc : r_q[1];
            if (i_push) begin
                r_q[1] <= i_desc;
            end
        end else if (i_push) begin
            r_q[wr_slot] <= i_desc;
        end
    end

    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full && !i_pop, "push into full queue")
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && !o_valid, "pop from empty queue")

endmodule

// ----- design/blp_back.sv -----
// Back end: walks one line a pixel per cycle with an error accumulator.
`include "assert_macros.svh"

module blp_back #(
    parameter int COORD_BITS = blp_pkg::CoordBitsDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  blp_pkg::t_desc  i_desc,
    output logic            o_pop,
    output logic            o_pixel_valid,
    output blp_pkg::t_pixel o_pixel
);

    localparam int AccW = COORD_BITS + 2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state                   r_state, n_state;
    logic [COORD_BITS-1:0]    r_m, r_n, r_left, r_dm, r_dn;
    logic signed [AccW-1:0]   r_acc;
    logic                     r_steep, r_up;
    logic [blp_pkg::ColorW-1:0] r_color;
    logic                     r_out_valid;
    blp_pkg::t_pixel          r_out;

    logic                     running, last_step;
    logic signed [AccW-1:0]   acc_sum, half;
    logic                     minor_step;

    // Step control and error term
    always_comb begin
        running    = r_state == S_RUN;
        last_step  = running && (r_left == COORD_BITS'(1));
        o_pop      = i_q_valid && ((r_state == S_IDLE) || last_step);
        acc_sum    = r_acc + AccW'(r_dn);
        half       = AccW'(r_dm >> 1);
        minor_step = acc_sum > half;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_pop) n_state = S_RUN;
            end
            S_RUN: begin
                if (last_step && !o_pop) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= running;
        end
    end

    // Walk registers: load a new line or advance one pixel
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_m     <= i_desc.m0[COORD_BITS-1:0];
            r_n     <= i_desc.n0[COORD_BITS-1:0];
            r_left  <= i_desc.dm[COORD_BITS-1:0];
            r_dm    <= i_desc.dm[COORD_BITS-1:0];
            r_dn    <= i_desc.dn[COORD_BITS-1:0];
            r_steep <= i_desc.steep;
            r_up    <= i_desc.minor_up;
            r_color <= i_desc.color;
            r_acc   <= '0;
        end else if (running) begin
            r_m    <= r_m + COORD_BITS'(1);
            r_left <= r_left - COORD_BITS'(1);
            if (minor_step) begin
                r_n   <= r_up ? r_n + COORD_BITS'(1) : r_n - COORD_BITS'(1);
                r_acc <= acc_sum - AccW'(r_dm);
            end else begin
                r_acc <= acc_sum;
            end
        end
    end

    // Output register, axes swapped back for steep lines
    always_ff @(posedge i_clk) begin
        if (running) begin
            r_out.pixel_x     <= blp_pkg::CoordW'(r_steep ? r_n : r_m);
            r_out.pixel_y     <= blp_pkg::CoordW'(r_steep ? r_m : r_n);
            r_out.pixel_color <= r_color;
            r_out.last_pixel  <= last_step;
        end
    end

    assign o_pixel_valid = r_out_valid;
    assign o_pixel       = r_out;

    `ASSERT_NEVER(a_run_empty, i_clk, i_rst_n, running && (r_left == '0), "walk with no pixels left")
    `ASSERT_HOLDS(a_out_src, i_clk, i_rst_n, o_pixel_valid |-> $past(running), "pixel without a walk step")

endmodule

// ----- design/bresenham_line_pixels_core.sv -----
// Top level of the Bresenham line rasteriser for one square tile.
//
// Channel   Direction  Handshake                    Payload
// command   in         start && !busy               i_cmd   (blp_pkg::t_cmd)
// pixel     out        o_pixel_valid, one cycle     o_pixel (blp_pkg::t_pixel)
//
// A line of major extent d gives d pixels, one per cycle from the walker.
// A taken command passes through the queue, walk and output registers to the
// ports; lines queued behind it follow with no gap, so the walker is the rate limit.
// Zero-length lines are dropped in the front end and give no pixel.
// busy is high while the two-entry command queue is full.
// Reset is synchronous and active low; pixels are never held off.
module bresenham_line_pixels_core #(
    parameter int COORD_BITS = blp_pkg::CoordBitsDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  blp_pkg::t_cmd   i_cmd,
    output logic            o_pixel_valid,
    output blp_pkg::t_pixel o_pixel
);

    logic           push, pop, full, q_valid;
    blp_pkg::t_desc front_desc, q_desc;

    assign busy = full;

    // Classify incoming items
    blp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_start (start),
        .i_full  (full),
        .i_cmd   (i_cmd),
        .o_push  (push),
        .o_desc  (front_desc)
    );

    // Decouple front and walker
    blp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (front_desc),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    // Pixel walker
    blp_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_desc        (q_desc),
        .o_pop         (pop),
        .o_pixel_valid (o_pixel_valid),
        .o_pixel       (o_pixel)
    );

endmodule
